[rtl/core/segment_segment_intersection_assert.svh]
// Assertion macros for the segment intersection block.
// Used by the port checker; needs nothing else.
`ifndef SEGMENT_SEGMENT_INTERSECTION_ASSERT_SVH
`define SEGMENT_SEGMENT_INTERSECTION_ASSERT_SVH

// Check a property at every rising edge outside reset.
`define SSI_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property at every rising edge, reset included.
`define SSI_ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/core/ssi_pkg.sv]
// Shared types and widths for the segment intersection pipeline.
// No dependencies; every module of the block imports it.
package ssi_pkg;

   localparam int COORD_BITS = 16;
   localparam int THR_BITS   = 16;

   // Intermediate widths, all derived from the coordinate width.
   localparam int DIFF_W    = COORD_BITS + 1;     // endpoint difference
   localparam int PROD_W    = 2 * DIFF_W;         // one cross product term
   localparam int DET_W     = PROD_W + 1;         // determinant and numerator
   localparam int DC_W      = DIFF_W + DET_W;     // |direction| * |numerator|
   localparam int NUM_W     = DC_W + 2;           // rounded dividend magnitude
   localparam int DIVS_W    = DET_W + 1;          // divisor, twice the determinant
   localparam int QB        = COORD_BITS + 1;     // quotient bits before saturation
   localparam int T_W       = QB + 2;             // signed offset along a segment
   localparam int PT_W      = T_W + 1;            // unsaturated crossing coordinate
   localparam int FRONT_LAT = 7;                  // register stages in the front end
   localparam int DIV_LAT   = QB + 2;             // register stages in a divider

   localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(128);
   localparam logic signed [T_W-1:0] T_SAT   = T_W'(1) << QB;

   typedef logic signed [COORD_BITS-1:0] coord_type;

   localparam coord_type COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
   localparam coord_type COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

   typedef struct packed {
      coord_type a_start_x;
      coord_type a_start_y;
      coord_type a_end_x;
      coord_type a_end_y;
      coord_type b_start_x;
      coord_type b_start_y;
      coord_type b_end_x;
      coord_type b_end_y;
   } ssi_req_type;

   typedef struct packed {
      logic      hit;
      coord_type cross_x;
      coord_type cross_y;
   } ssi_rsp_type;

   // Dividend magnitude, its sign and the divisor for one rounded ratio.
   typedef struct packed {
      logic              neg;
      logic [NUM_W-1:0]  mag;
      logic [DIVS_W-1:0] den2;
   } ssi_num_type;

   // Data that rides alongside the dividers.
   typedef struct packed {
      ssi_req_type pts;
      logic        par;
   } ssi_side_type;

endpackage

[rtl/core/ssi_front.sv]
// Front end: differences, cross products, determinant test and dividends.
// Depends on ssi_pkg.
module ssi_front import ssi_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic                in_valid,
   input  ssi_req_type         in_data,
   input  logic [THR_BITS-1:0] threshold,
   output logic                out_valid,
   output ssi_num_type         out_num_x,
   output ssi_num_type         out_num_y,
   output ssi_side_type        out_side
);

   function automatic logic signed [DIFF_W-1:0] sext(input coord_type v);
      return {v[COORD_BITS-1], v};
   endfunction

   // Form the signed dividend 2*w + den, w = -d*c, as magnitude and sign.
   function automatic ssi_num_type num_form(input logic neg, input logic [DC_W-1:0] mag,
                                            input logic [DET_W-1:0] den);
      logic [NUM_W-1:0] two;
      logic [NUM_W-1:0] d;
      logic [NUM_W-1:0] sum;
      logic [NUM_W-1:0] up;
      logic [NUM_W-1:0] down;
      ssi_num_type      r;
      two    = {1'b0, mag, 1'b0};
      d      = NUM_W'(den);
      sum    = two + d;
      up     = two - d;
      down   = d - two;
      r.den2 = {den, 1'b0};
      if (!neg) begin
         r.neg = 1'b0;
         r.mag = sum;
      end else if (!up[NUM_W-1] && up != '0) begin
         r.neg = 1'b1;
         r.mag = up;
      end else begin
         r.neg = 1'b0;
         r.mag = down;
      end
      return r;
   endfunction

   logic [FRONT_LAT-1:0] v_ff;
   ssi_req_type          pts_ff [FRONT_LAT];

   logic signed [DIFF_W-1:0] dx1_in, dy1_in, dx2_in, dy2_in, ex_in, ey_in;
   logic signed [DIFF_W-1:0] dx1_ff, dy1_ff, dx2_ff, dy2_ff, ex_ff, ey_ff;

   logic signed [PROD_W-1:0] pa_in, pb_in, pc_in, pd_in;
   logic signed [PROD_W-1:0] pa_ff, pb_ff, pc_ff, pd_ff;
   logic signed [DIFF_W-1:0] dx1_3_ff, dy1_3_ff;

   logic signed [DET_W-1:0]  den_in, c_in, den_ff, c_ff;
   logic signed [DIFF_W-1:0] dx1_4_ff, dy1_4_ff;

   logic [DET_W-1:0]  den_mag_in, den_mag_ff, c_mag_in, c_mag_ff;
   logic [DIFF_W-1:0] dx_mag_in, dx_mag_ff, dy_mag_in, dy_mag_ff;
   logic              c_neg_in, c_neg_ff, par_in, par5_ff;
   logic              dx_neg_ff, dy_neg_ff;

   logic [DC_W-1:0]  mx_in, mx_ff, my_in, my_ff;
   logic             nx_in, nx_ff, ny_in, ny_ff;
   logic [DET_W-1:0] den6_ff;
   logic             par6_ff;

   ssi_num_type num_x_in, num_x_ff, num_y_in, num_y_ff;
   logic        par7_ff;

   always_comb begin
      // Direction vectors of both segments and offset from A to B.
      dx1_in = sext(pts_ff[0].a_start_x) - sext(pts_ff[0].a_end_x);
      dy1_in = sext(pts_ff[0].a_start_y) - sext(pts_ff[0].a_end_y);
      dx2_in = sext(pts_ff[0].b_start_x) - sext(pts_ff[0].b_end_x);
      dy2_in = sext(pts_ff[0].b_start_y) - sext(pts_ff[0].b_end_y);
      ex_in  = sext(pts_ff[0].b_start_x) - sext(pts_ff[0].a_start_x);
      ey_in  = sext(pts_ff[0].b_start_y) - sext(pts_ff[0].a_start_y);

      pa_in = dx1_ff * dy2_ff;
      pb_in = dy1_ff * dx2_ff;
      pc_in = dx2_ff * ey_ff;
      pd_in = dy2_ff * ex_ff;

      den_in = {pa_ff[PROD_W-1], pa_ff} - {pb_ff[PROD_W-1], pb_ff};
      c_in   = {pc_ff[PROD_W-1], pc_ff} - {pd_ff[PROD_W-1], pd_ff};

      // Fold the determinant sign into the numerator sign.
      den_mag_in = den_ff[DET_W-1] ? -den_ff : den_ff;
      c_mag_in   = c_ff[DET_W-1] ? -c_ff : c_ff;
      c_neg_in   = c_ff[DET_W-1] ^ den_ff[DET_W-1];
      dx_mag_in  = dx1_4_ff[DIFF_W-1] ? -dx1_4_ff : dx1_4_ff;
      dy_mag_in  = dy1_4_ff[DIFF_W-1] ? -dy1_4_ff : dy1_4_ff;
      par_in     = (den_ff == '0) || (den_mag_in < DET_W'(threshold));

      // The quotient is negative when direction and numerator agree in sign.
      mx_in = dx_mag_ff * c_mag_ff;
      my_in = dy_mag_ff * c_mag_ff;
      nx_in = dx_neg_ff == c_neg_ff;
      ny_in = dy_neg_ff == c_neg_ff;

      num_x_in = num_form(nx_ff, mx_ff, den6_ff);
      num_y_in = num_form(ny_ff, my_ff, den6_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[FRONT_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pts_ff[0] <= in_data;
         for (int i = 1; i < FRONT_LAT; i++) begin
            pts_ff[i] <= pts_ff[i-1];
         end
         dx1_ff     <= dx1_in;
         dy1_ff     <= dy1_in;
         dx2_ff     <= dx2_in;
         dy2_ff     <= dy2_in;
         ex_ff      <= ex_in;
         ey_ff      <= ey_in;
         pa_ff      <= pa_in;
         pb_ff      <= pb_in;
         pc_ff      <= pc_in;
         pd_ff      <= pd_in;
         dx1_3_ff   <= dx1_ff;
         dy1_3_ff   <= dy1_ff;
         den_ff     <= den_in;
         c_ff       <= c_in;
         dx1_4_ff   <= dx1_3_ff;
         dy1_4_ff   <= dy1_3_ff;
         den_mag_ff <= den_mag_in;
         c_mag_ff   <= c_mag_in;
         c_neg_ff   <= c_neg_in;
         dx_mag_ff  <= dx_mag_in;
         dy_mag_ff  <= dy_mag_in;
         dx_neg_ff  <= dx1_4_ff[DIFF_W-1];
         dy_neg_ff  <= dy1_4_ff[DIFF_W-1];
         par5_ff    <= par_in;
         mx_ff      <= mx_in;
         my_ff      <= my_in;
         nx_ff      <= nx_in;
         ny_ff      <= ny_in;
         den6_ff    <= den_mag_ff;
         par6_ff    <= par5_ff;
         num_x_ff   <= num_x_in;
         num_y_ff   <= num_y_in;
         par7_ff    <= par6_ff;
      end
   end

   assign out_valid     = v_ff[FRONT_LAT-1];
   assign out_num_x     = num_x_ff;
   assign out_num_y     = num_y_ff;
   assign out_side.pts  = pts_ff[FRONT_LAT-1];
   assign out_side.par  = par7_ff;

endmodule

[rtl/core/ssi_div.sv]
// Pipelined restoring divider, one quotient bit per stage, round to nearest.
// Depends on ssi_pkg.
module ssi_div import ssi_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  ssi_num_type           in_num,
   output logic                  out_valid,
   output logic signed [T_W-1:0] out_t
);

   logic [DIV_LAT-1:0] v_ff;
   logic [NUM_W-1:0]   rem_ff [QB+1];
   logic [DIVS_W-1:0]  den_ff [QB+1];
   logic [QB-1:0]      q_ff   [QB+1];
   logic [QB:0]        neg_ff;
   logic [QB:0]        ovf_ff;

   logic               ovf_in;
   logic [NUM_W-1:0]   dsh    [1:QB];
   logic [NUM_W-1:0]   rem_in [1:QB];
   logic [QB-1:0]      q_in   [1:QB];
   logic [QB:1]        ge;

   logic [QB:0]           qr;
   logic signed [T_W-1:0] t_in, t_ff;

   always_comb begin
      // Quotient at or beyond full scale: saturate.
      ovf_in = in_num.mag >= (NUM_W'(in_num.den2) << QB);
      for (int k = 1; k <= QB; k++) begin
         dsh[k]    = NUM_W'(den_ff[k-1]) << (QB - k);
         ge[k]     = rem_ff[k-1] >= dsh[k];
         rem_in[k] = ge[k] ? rem_ff[k-1] - dsh[k] : rem_ff[k-1];
         q_in[k]   = q_ff[k-1] | (QB'(ge[k]) << (QB - k));
      end
      // Negative dividend: floor is minus the quotient rounded up.
      qr = {1'b0, q_ff[QB]} + (QB + 1)'(rem_ff[QB] != '0);
      if (ovf_ff[QB]) begin
         t_in = neg_ff[QB] ? -T_SAT : T_SAT;
      end else if (neg_ff[QB]) begin
         t_in = -T_W'(qr);
      end else begin
         t_in = T_W'(q_ff[QB]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (adv) begin
         v_ff <= {v_ff[DIV_LAT-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= in_num.mag;
         den_ff[0] <= in_num.den2;
         q_ff[0]   <= '0;
         neg_ff[0] <= in_num.neg;
         ovf_ff[0] <= ovf_in;
         for (int k = 1; k <= QB; k++) begin
            rem_ff[k] <= rem_in[k];
            den_ff[k] <= den_ff[k-1];
            q_ff[k]   <= q_in[k];
            neg_ff[k] <= neg_ff[k-1];
            ovf_ff[k] <= ovf_ff[k-1];
         end
         t_ff <= t_in;
      end
   end

   assign out_valid = v_ff[DIV_LAT-1];
   assign out_t     = t_ff;

endmodule

[rtl/core/ssi_back.sv]
// Back end: crossing point, containment on both segments, saturation.
// Depends on ssi_pkg.
module ssi_back import ssi_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  adv,
   input  logic                  in_valid,
   input  logic signed [T_W-1:0] t_x,
   input  logic signed [T_W-1:0] t_y,
   input  ssi_side_type          in_side,
   output logic                  out_valid,
   output ssi_rsp_type           out_data
);

   function automatic logic signed [PT_W-1:0] pext(input coord_type v);
      return {{(PT_W-COORD_BITS){v[COORD_BITS-1]}}, v};
   endfunction

   function automatic logic signed [PT_W-1:0] text(input logic signed [T_W-1:0] v);
      return {{(PT_W-T_W){v[T_W-1]}}, v};
   endfunction

   function automatic logic in_span(input logic signed [PT_W-1:0] v,
                                    input coord_type a, input coord_type b);
      logic signed [PT_W-1:0] lo;
      logic signed [PT_W-1:0] hi;
      lo = (a < b) ? pext(a) : pext(b);
      hi = (a < b) ? pext(b) : pext(a);
      return (v >= lo) && (v <= hi);
   endfunction

   function automatic logic holds(input logic signed [PT_W-1:0] x,
                                  input logic signed [PT_W-1:0] y,
                                  input coord_type sx, input coord_type sy,
                                  input coord_type ex, input coord_type ey);
      return ((sx != ex) && in_span(x, sx, ex)) || ((sy != ey) && in_span(y, sy, ey));
   endfunction

   function automatic coord_type sat(input logic signed [PT_W-1:0] v);
      coord_type r;
      if (v > pext(COORD_MAX)) begin
         r = COORD_MAX;
      end else if (v < pext(COORD_MIN)) begin
         r = COORD_MIN;
      end else begin
         r = v[COORD_BITS-1:0];
      end
      return r;
   endfunction

   logic                   v_ff;
   logic signed [PT_W-1:0] x_in, y_in, x_ff, y_ff;
   ssi_side_type           side_ff;
   logic                   hit;

   always_comb begin
      x_in = pext(in_side.pts.a_start_x) + text(t_x);
      y_in = pext(in_side.pts.a_start_y) + text(t_y);
      hit  = !side_ff.par
           && holds(x_ff, y_ff, side_ff.pts.a_start_x, side_ff.pts.a_start_y,
                    side_ff.pts.a_end_x, side_ff.pts.a_end_y)
           && holds(x_ff, y_ff, side_ff.pts.b_start_x, side_ff.pts.b_start_y,
                    side_ff.pts.b_end_x, side_ff.pts.b_end_y);
      out_data = '0;
      if (hit) begin
         out_data.hit     = 1'b1;
         out_data.cross_x = sat(x_ff);
         out_data.cross_y = sat(y_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (adv) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = v_ff;

endmodule

[rtl/core/segment_segment_intersection.sv]
// Segment intersection top level: front end, two dividers, back end, output skid.
// Throughput: one transfer per cycle while the output skid slot is empty.
// Synchronous active-high reset empties the pipeline and loads the threshold with 128.
// Depends on ssi_pkg, ssi_front, ssi_div and ssi_back.
module segment_segment_intersection import ssi_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   // Input channel: a pair of segments per transfer
   input  logic                req_valid,
   output logic                req_stall,
   input  ssi_req_type         req_data,
   // Result channel: one result per input transfer
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ssi_rsp_type         rsp_data,
   // Threshold register write channel
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [THR_BITS-1:0] csr_data
);

   logic [THR_BITS-1:0] thr_ff;

   // The whole pipeline moves as one; it halts only while the skid slot is full.
   logic adv;

   logic         front_valid;
   ssi_num_type  num_x, num_y;
   ssi_side_type front_side;

   logic                  div_x_valid, div_y_valid;
   logic signed [T_W-1:0] t_x, t_y;
   ssi_side_type          side_ff [DIV_LAT];

   logic        back_valid;
   ssi_rsp_type back_data;

   logic        rsp_v_in, rsp_v_ff, skid_v_in, skid_v_ff;
   ssi_rsp_type rsp_d_in, rsp_d_ff, skid_d_in, skid_d_ff;
   logic        rsp_free;

   // Threshold register: always ready, written on every transfer.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
      end else if (csr_valid) begin
         thr_ff <= csr_data;
      end
   end

   assign adv       = !skid_v_ff;
   assign req_stall = skid_v_ff;

   // Differences, products, determinant test and rounded dividends.
   ssi_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .threshold (thr_ff),
      .out_valid (front_valid),
      .out_num_x (num_x),
      .out_num_y (num_y),
      .out_side  (front_side)
   );

   // One divider per axis; both run in lock step.
   ssi_div u_div_x (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (front_valid),
      .in_num    (num_x),
      .out_valid (div_x_valid),
      .out_t     (t_x)
   );

   ssi_div u_div_y (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (front_valid),
      .in_num    (num_y),
      .out_valid (div_y_valid),
      .out_t     (t_y)
   );

   // Carry the endpoints and the parallel flag alongside the dividers.
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= front_side;
         for (int i = 1; i < DIV_LAT; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   ssi_back u_back (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (div_x_valid && div_y_valid),
      .t_x       (t_x),
      .t_y       (t_y),
      .in_side   (side_ff[DIV_LAT-1]),
      .out_valid (back_valid),
      .out_data  (back_data)
   );

   // Output register plus one skid slot. A result arriving while the output is
   // stalled drops into the skid slot; the pipeline then holds until it drains.
   assign rsp_free = !rsp_v_ff || !rsp_stall;

   always_comb begin
      rsp_v_in  = rsp_v_ff;
      rsp_d_in  = rsp_d_ff;
      skid_v_in = skid_v_ff;
      skid_d_in = skid_d_ff;
      if (rsp_free) begin
         if (skid_v_ff) begin
            rsp_v_in  = 1'b1;
            rsp_d_in  = skid_d_ff;
            skid_v_in = 1'b0;
         end else begin
            rsp_v_in = back_valid;
            rsp_d_in = back_data;
         end
      end else if (!skid_v_ff && back_valid) begin
         skid_v_in = 1'b1;
         skid_d_in = back_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         rsp_v_ff  <= rsp_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_d_ff  <= rsp_d_in;
      skid_d_ff <= skid_d_in;
   end

   assign rsp_valid = rsp_v_ff;
   assign rsp_data  = rsp_d_ff;

endmodule

[rtl/core/ssi_checker.sv]
// Port-level checker for the segment intersection block, bound to the top level.
// Depends on ssi_pkg and segment_segment_intersection_assert.svh.
`include "segment_segment_intersection_assert.svh"

module ssi_checker import ssi_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input ssi_rsp_type rsp_data
);

   `SSI_ASSERT_NORST(a_reset_empty, clock, reset |=> !rsp_valid && !req_stall, "pipeline not empty after reset")
   `SSI_ASSERT(a_zero_without_hit, clock, reset, rsp_valid && !rsp_data.hit |-> rsp_data.cross_x == '0 && rsp_data.cross_y == '0, "crossing point set without hit")
   `SSI_ASSERT(a_stall_cause, clock, reset, $rose(req_stall) |-> $past(rsp_valid && rsp_stall), "input stalled without a stalled result")
   `SSI_ASSERT(a_skid_implies_out, clock, reset, req_stall |-> rsp_valid, "input stalled with output empty")
   `SSI_ASSERT(a_hold_result, clock, reset, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data), "stalled result changed")

endmodule

bind segment_segment_intersection ssi_checker u_ssi_checker (.*);

[test/segment_segment_intersection_test.sv]
`timescale 1ns / 1ps
// Self-checking bench for segment_segment_intersection: directed and random segment pairs.
// Checks every result against its typed row or a bit-exact crossing predictor. Depends on ssi_pkg and the block.
module segment_segment_intersection_test;
   import ssi_pkg::*;

   // Run shape
   localparam int RESET_CYCLES  = 11;
   localparam int SETTLE_CYCLES = 40;     // margin over the pipeline depth, allow for the output skid
   localparam int HOLD_CYCLES   = 400;    // long receiver hold-off, well past the pipeline depth
   localparam int QUIET_LIMIT   = 4000;   // cycles with no transfer at all before giving up
   localparam int REPORT_LIMIT  = 50;
   localparam int N_DIRECTED    = 20;
   localparam longint OFFSET_LIM = longint'(1) << (COORD_BITS + 2);

   typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_SPARSE} stall_pattern_type;

   // One directed row: segment A, segment B, and a typed result where it is obvious.
   typedef struct {
      int ax0, ay0, ax1, ay1;
      int bx0, by0, bx1, by1;
      bit typed;
      bit hit;
      int want_x, want_y;
   } directed_row_type;

   // Rows marked typed assume the threshold out of reset (128).
   directed_row_type directed_rows [N_DIRECTED] = '{
      // degenerate whole items: zero determinant, no hit
      '{0, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0},
      '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 1, 0, 0, 0},
      '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, 1, 0, 0, 0},
      // segment A collapsed to a point
      '{100, 100, 100, 100, 0, 0, 200, 200, 1, 0, 0, 0},
      // parallel and colinear
      '{0, 0, 64, 0, 0, 16, 64, 16, 1, 0, 0, 0},
      '{0, 0, 64, 64, 32, 32, 96, 96, 1, 0, 0, 0},
      // plain perpendicular crossing
      '{0, 16, 64, 16, 32, 0, 32, 64, 1, 1, 32, 16},
      // B starts on the end of A: ends count as inside
      '{0, 0, 64, 0, 64, 0, 64, 64, 1, 1, 64, 0},
      // lines cross just past the end of A
      '{0, 0, 64, 0, 80, -32, 80, 32, 1, 0, 0, 0},
      // determinant exactly at the threshold still counts
      '{0, 0, 16, 0, 8, -4, 8, 4, 1, 1, 8, 0},
      // determinant one below the threshold is parallel
      '{0, 0, 127, 0, 64, 0, 64, 1, 1, 0, 0, 0},
      // crossing far outside the coordinate range
      '{0, 0, 32767, 0, 0, 16, 32767, 17, 1, 0, 0, 0},
      // full-range diagonals: crossing at -1/2, ties round up to zero
      '{-32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768, 1, 1, 0, 0},
      // the rest go through the predictor
      '{64, 16, 0, 16, 32, 0, 32, 64, 0, 0, 0, 0},
      '{0, 0, 16, 1, 0, 1, 16, 0, 0, 0, 0, 0},
      '{0, 0, 16, -1, 0, -1, 16, 0, 0, 0, 0, 0},
      '{0, -64, 0, 64, -64, -32, 64, 32, 0, 0, 0, 0},
      '{-100, -37, 250, 91, -50, 200, 180, -150, 0, 0, 0, 0},
      '{-32768, 0, 32767, 0, 0, -32768, 0, 32767, 0, 0, 0, 0},
      '{32767, -32768, -32768, -32767, -32768, 32767, 32767, 32766, 0, 0, 0, 0}
   };

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   ssi_req_type         req_data = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   ssi_rsp_type         rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [THR_BITS-1:0] csr_data = '0;

   // Threshold as the block should hold it, and results still owed by the block
   logic [THR_BITS-1:0] threshold_setting = THR_RESET;
   ssi_rsp_type         expected_crossings [$];

   int mismatch_count = 0;
   int result_count   = 0;
   int quiet_cycles   = 0;
   int hold_requests  = 0;
   int hold_grants    = 0;
   int burst_left     = 1;
   int gap_max        = 0;

   segment_segment_intersection dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   // Offset along a segment: round(-dir * num / det) to nearest, ties upward, then
   // clamp to a bound that already lies outside every segment. det is positive.
   function automatic longint rounded_offset(longint dir, longint num, longint det);
      longint dividend, quotient;
      dividend = -2 * dir * num + det;
      quotient = dividend / (2 * det);
      // integer division truncates, so step down for negative remainders to get a floor
      if (dividend < 0 && (dividend % (2 * det)) != 0)
         quotient = quotient - 1;
      if (quotient > OFFSET_LIM)
         quotient = OFFSET_LIM;
      else if (quotient < -OFFSET_LIM)
         quotient = -OFFSET_LIM;
      return quotient;
   endfunction

   // A segment holds the point if it lies in a nonzero x span or a nonzero y span.
   function automatic bit on_segment(longint px, longint py,
                                     longint sx, longint sy, longint ex, longint ey);
      bit in_x, in_y;
      in_x = (sx != ex) && px >= (sx < ex ? sx : ex) && px <= (sx < ex ? ex : sx);
      in_y = (sy != ey) && py >= (sy < ey ? sy : ey) && py <= (sy < ey ? ey : sy);
      return in_x || in_y;
   endfunction

   function automatic coord_type clamp_coord(longint v);
      if (v > longint'(COORD_MAX))
         return COORD_MAX;
      if (v < longint'(COORD_MIN))
         return COORD_MIN;
      return coord_type'(v);
   endfunction

   function automatic ssi_rsp_type predict_crossing(ssi_req_type p, logic [THR_BITS-1:0] thr);
      longint x1, y1, x2, y2, x3, y3, x4, y4;
      longint dx1, dy1, dx2, dy2, det, num, px, py;
      ssi_rsp_type r;
      r = '0;
      x1 = p.a_start_x;  y1 = p.a_start_y;  x2 = p.a_end_x;  y2 = p.a_end_y;
      x3 = p.b_start_x;  y3 = p.b_start_y;  x4 = p.b_end_x;  y4 = p.b_end_y;
      dx1 = x1 - x2;
      dy1 = y1 - y2;
      dx2 = x3 - x4;
      dy2 = y3 - y4;
      det = dx1 * dy2 - dy1 * dx2;
      // zero is parallel whatever the threshold
      if (det == 0 || (det < 0 ? -det : det) < longint'(thr))
         return r;
      num = dx2 * (y3 - y1) - dy2 * (x3 - x1);
      if (det < 0) begin
         det = -det;
         num = -num;
      end
      px = x1 + rounded_offset(dx1, num, det);
      py = y1 + rounded_offset(dy1, num, det);
      // containment uses the unclamped point; clamping is for the output only
      if (on_segment(px, py, x1, y1, x2, y2) && on_segment(px, py, x3, y3, x4, y4)) begin
         r.hit     = 1'b1;
         r.cross_x = clamp_coord(px);
         r.cross_y = clamp_coord(py);
      end
      return r;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic coord_type corner_value();
      case ($urandom_range(4, 0))
         0:       return COORD_MIN;
         1:       return COORD_MAX;
         2:       return '0;
         3:       return '1;
         default: return coord_type'($urandom());
      endcase
   endfunction

   // Mostly pairs drawn from one local box, so they cross often; the rest are
   // near-parallel, shared-endpoint, full-range, corner-value and collapsed pairs.
   function automatic ssi_req_type random_pair();
      ssi_req_type pair;
      int roll, size, base_x, base_y, dx, dy;
      roll   = $urandom_range(99, 0);
      size   = (1 << $urandom_range(15, 2)) - 1;
      base_x = int'($urandom_range(65535 - size, 0)) - 32768;
      base_y = int'($urandom_range(65535 - size, 0)) - 32768;
      pair.a_start_x = coord_type'(base_x + int'($urandom_range(size, 0)));
      pair.a_start_y = coord_type'(base_y + int'($urandom_range(size, 0)));
      pair.a_end_x   = coord_type'(base_x + int'($urandom_range(size, 0)));
      pair.a_end_y   = coord_type'(base_y + int'($urandom_range(size, 0)));
      pair.b_start_x = coord_type'(base_x + int'($urandom_range(size, 0)));
      pair.b_start_y = coord_type'(base_y + int'($urandom_range(size, 0)));
      pair.b_end_x   = coord_type'(base_x + int'($urandom_range(size, 0)));
      pair.b_end_y   = coord_type'(base_y + int'($urandom_range(size, 0)));
      if (roll >= 50 && roll < 65) begin
         // shift A a little and nudge one end: determinant lands near the threshold
         dx = int'($urandom_range(64, 0)) - 32;
         dy = int'($urandom_range(64, 0)) - 32;
         pair.b_start_x = pair.a_start_x + coord_type'(dx);
         pair.b_start_y = pair.a_start_y + coord_type'(dy);
         pair.b_end_x   = pair.a_end_x + coord_type'(dx + int'($urandom_range(6, 0)) - 3);
         pair.b_end_y   = pair.a_end_y + coord_type'(dy + int'($urandom_range(6, 0)) - 3);
      end else if (roll >= 65 && roll < 75) begin
         if ($urandom_range(1, 0)) begin
            pair.b_start_x = pair.a_start_x;
            pair.b_start_y = pair.a_start_y;
         end else begin
            pair.b_start_x = pair.a_end_x;
            pair.b_start_y = pair.a_end_y;
         end
      end else if (roll >= 75 && roll < 85) begin
         pair = {$urandom(), $urandom(), $urandom(), $urandom()};
      end else if (roll >= 85 && roll < 95) begin
         pair = {corner_value(), corner_value(), corner_value(), corner_value(),
                 corner_value(), corner_value(), corner_value(), corner_value()};
      end else if (roll >= 95) begin
         if ($urandom_range(1, 0)) begin
            pair.a_end_x = pair.a_start_x;
            pair.a_end_y = pair.a_start_y;
         end else begin
            pair.b_end_x = pair.b_start_x;
            pair.b_end_y = pair.b_start_y;
         end
      end
      return pair;
   endfunction

   // Offer one pair and hold it until the transfer; then either carry on with the
   // burst (valid stays high) or drop valid for a random gap.
   task automatic offer_pair(input ssi_req_type pair, input bit typed, input ssi_rsp_type want);
      int gap;
      req_valid <= 1'b1;
      req_data  <= pair;
      do @(posedge clock); while (req_stall);
      expected_crossings.insert(expected_crossings.size(),
                                typed ? want : predict_crossing(pair, threshold_setting));
      burst_left--;
      if (burst_left <= 0) begin
         burst_left = $urandom_range(24, 1);
         gap        = $urandom_range(gap_max, 0);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Stop offering, wait for every owed result, then let the pipeline settle.
   task automatic drain_crossings();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_crossings.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_threshold(input logic [THR_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(input int count, input int gaps, input bit long_hold);
      int n;
      gap_max = gaps;
      // ask the receiver for a long hold-off while the sender keeps offering
      if (long_hold)
         hold_requests <= hold_requests + 1;
      for (n = 0; n < count; n++)
         offer_pair(random_pair(), 1'b0, '0);
   endtask

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string msg);
      if (mismatch_count < REPORT_LIMIT)
         $display("ERROR at %0t ns, result %0d: %s", $time, result_count, msg);
      mismatch_count++;
   endtask

   // Track the threshold register the way the block should
   always @(posedge clock) begin
      if (reset)
         threshold_setting <= THR_RESET;
      else if (csr_valid && csr_ready)
         threshold_setting <= csr_data;
   end

   // Compare each result transfer with the oldest expectation, field by field
   always @(posedge clock) begin : check_results
      ssi_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_crossings.size() == 0) begin
            report_mismatch($sformatf("result with nothing outstanding (hit %0b x %0d y %0d)",
                                      rsp_data.hit, rsp_data.cross_x, rsp_data.cross_y));
         end else begin
            want = expected_crossings.pop_front();
            if (rsp_data.hit !== want.hit)
               report_mismatch($sformatf("hit %0b, expected %0b", rsp_data.hit, want.hit));
            if (rsp_data.cross_x !== want.cross_x)
               report_mismatch($sformatf("cross_x %0d, expected %0d",
                                         rsp_data.cross_x, want.cross_x));
            if (rsp_data.cross_y !== want.cross_y)
               report_mismatch($sformatf("cross_y %0d, expected %0d",
                                         rsp_data.cross_y, want.cross_y));
         end
         result_count++;
      end
   end

   // Watchdog: give up after a long run of cycles with no transfer on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Receiver back-pressure: stretches of random length, each on its own pattern,
   // with a long hold-off whenever one is requested.
   initial begin
      stall_pattern_type pattern;
      int span, density, period, on_cycles, phase;
      forever begin
         pattern   = stall_pattern_type'($urandom_range(3, 0));
         span      = $urandom_range(200, 20);
         density   = $urandom_range(70, 10);
         period    = $urandom_range(12, 2);
         on_cycles = $urandom_range(period - 1, 1);
         for (phase = 0; phase < span; phase++) begin
            @(posedge clock);
            if (hold_requests != hold_grants) begin
               // hold the output long enough to fill the pipeline and stall the input
               rsp_stall <= 1'b1;
               repeat (HOLD_CYCLES) @(posedge clock);
               hold_grants <= hold_requests;
            end else begin
               case (pattern)
                  STALL_NONE:     rsp_stall <= 1'b0;
                  STALL_RANDOM:   rsp_stall <= ($urandom_range(99, 0) < density);
                  STALL_PERIODIC: rsp_stall <= ((phase % period) < on_cycles);
                  default:        rsp_stall <= ($urandom_range(19, 0) == 0);
               endcase
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      int row;
      ssi_req_type pair;
      ssi_rsp_type want;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed table at the threshold out of reset
      gap_max = 3;
      for (row = 0; row < N_DIRECTED; row++) begin
         pair = {coord_type'(directed_rows[row].ax0), coord_type'(directed_rows[row].ay0),
                 coord_type'(directed_rows[row].ax1), coord_type'(directed_rows[row].ay1),
                 coord_type'(directed_rows[row].bx0), coord_type'(directed_rows[row].by0),
                 coord_type'(directed_rows[row].bx1), coord_type'(directed_rows[row].by1)};
         want = {directed_rows[row].hit, coord_type'(directed_rows[row].want_x),
                 coord_type'(directed_rows[row].want_y)};
         offer_pair(pair, directed_rows[row].typed, want);
      end

      // Threshold sweep: write only once the block has emptied
      drain_crossings();
      write_threshold('0);
      run_random(250, 8, 1'b0);

      drain_crossings();
      write_threshold('1);
      run_random(150, 4, 1'b0);

      drain_crossings();
      write_threshold(THR_BITS'($urandom_range(2048, 2)));
      run_random(250, 6, 1'b1);

      // back-to-back offers with no sender gaps
      drain_crossings();
      write_threshold(THR_BITS'(1));
      run_random(200, 0, 1'b0);

      drain_crossings();
      write_threshold(THR_RESET);
      run_random(400, 10, 1'b0);

      drain_crossings();
      if (mismatch_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

[segment_segment_intersection.f]
+incdir+rtl/core
rtl/core/ssi_pkg.sv
rtl/core/ssi_front.sv
rtl/core/ssi_div.sv
rtl/core/ssi_back.sv
rtl/core/segment_segment_intersection.sv
rtl/core/ssi_checker.sv
test/segment_segment_intersection_test.sv
